FILE: design/dead_reckoning_pose_update_defines.svh
// Assertion macros shared by the pose update block.
`ifndef DEAD_RECKONING_POSE_UPDATE_DEFINES_SVH
`define DEAD_RECKONING_POSE_UPDATE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define DRPU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define DRPU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/drpu_pkg.sv
// ----------------------------------------------------------------------------
// drpu_pkg
// Shared types, constants and the CORDIC arctangent table of the pose update.
// ----------------------------------------------------------------------------
package drpu_pkg;

    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int POSITION_BITS_DEF = 32;

    // Heading in half-centidegrees: a quarter, a half and three quarters of a turn
    localparam int ANGLE_BITS = 17;
    localparam logic [ANGLE_BITS-1:0] TURN_1Q = 17'd18000;
    localparam logic [ANGLE_BITS-1:0] TURN_2Q = 17'd36000;
    localparam logic [ANGLE_BITS-1:0] TURN_3Q = 17'd54000;

    // Offset that makes any 33-bit angle sum non-negative, a multiple of a turn
    localparam logic [33:0] U_OFFSET = 34'd4295016000;
    localparam int          U_STEPS  = 17;
    localparam logic [18:0] TURN_X1  = 19'd72000;
    localparam logic [18:0] TURN_X2  = 19'd144000;
    localparam logic [18:0] TURN_X3  = 19'd216000;

    // rem*pi*2^30/36000 split into whole part and fractional remainder
    localparam logic [16:0] PI_QUOT  = 17'd93701;
    localparam logic [14:0] PI_REM   = 15'd23426;
    localparam logic [28:0] ROUND_HALF = 29'd18000;
    localparam logic [24:0] RECIP_1125 = 25'd30541990;

    localparam logic signed [19:0] CORDIC_GAIN = 20'sd39797;
    localparam logic signed [19:0] ONE_POS     = 20'sd65536;
    localparam logic signed [19:0] ONE_NEG     = -20'sd65536;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic                  primed;
        logic signed [32:0]    ds;
        logic [ANGLE_BITS-1:0] angle;
    } drpu_job_t;

    // Arctangent of 2^-i in Q30
    function automatic logic [30:0] atan_q30(input logic [4:0] idx);
        logic [30:0] v;
        case (idx)
            5'd0:  v = 31'h3243F6A8;
            5'd1:  v = 31'h1DAC6705;
            5'd2:  v = 31'h0FADBAFC;
            5'd3:  v = 31'h07F56EA6;
            5'd4:  v = 31'h03FEAB76;
            5'd5:  v = 31'h01FFD55B;
            5'd6:  v = 31'h00FFFAAA;
            5'd7:  v = 31'h007FFF55;
            5'd8:  v = 31'h003FFFEA;
            5'd9:  v = 31'h001FFFFD;
            5'd10: v = 31'h000FFFFF;
            5'd11: v = 31'h0007FFFF;
            5'd12: v = 31'h0003FFFF;
            5'd13: v = 31'h0001FFFF;
            5'd14: v = 31'h0000FFFF;
            5'd15: v = 31'h00007FFF;
            5'd16: v = 31'h00003FFF;
            5'd17: v = 31'h00001FFF;
            5'd18: v = 31'h00000FFF;
            5'd19: v = 31'h000007FF;
            5'd20: v = 31'h000003FF;
            5'd21: v = 31'h000001FF;
            5'd22: v = 31'h000000FF;
            5'd23: v = 31'h0000007F;
            default: v = 31'h0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/dead_reckoning_pose_update.sv
// ----------------------------------------------------------------------------
// dead_reckoning_pose_update
// Differential odometry pose tracker with midpoint-arc update.
// ----------------------------------------------------------------------------
// Usage:
//   Sample channel: sample_valid/sample_stall carry right_count, left_count
//   and heading_centideg. Each request yields exactly one pose request,
//   pose_valid/pose_stall with pose_x and pose_y, in order.
//   The first sample after reset only primes the previous distance and
//   heading, and returns the reset pose (zero).
//   Path: the front reduces the angle in 17 radix-4 modulo steps, the
//   job leaves the queue, and the back runs the CORDIC rotator and the
//   position update. The back's shared CORDIC rotator sets the sample
//   rate; the front reduces the next sample alongside through a
//   two-entry queue, so it can take a new sample before the last pose is out.
//   Reset clears the kept pose, the previous sample and the queue.
//   A stalled pose holds in the output register; the back waits at the
//   position update, the queue fills and sample_stall then stays high.
// ----------------------------------------------------------------------------
module dead_reckoning_pose_update #(
    parameter int CORDIC_STEPS  = drpu_pkg::CORDIC_STEPS_DEF,
    parameter int POSITION_BITS = drpu_pkg::POSITION_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  logic signed [31:0] right_count,
    input  logic signed [31:0] left_count,
    input  logic signed [31:0] heading_centideg,
    output logic               pose_valid,
    input  logic               pose_stall,
    output logic signed [31:0] pose_x,
    output logic signed [31:0] pose_y
);
    import drpu_pkg::*;

    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;
    drpu_job_t q_in;
    drpu_job_t q_out;

    // sample intake and angle reduction
    drpu_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample_valid     (sample_valid),
        .sample_stall     (sample_stall),
        .right_count      (right_count),
        .left_count       (left_count),
        .heading_centideg (heading_centideg),
        .q_push           (q_push),
        .q_data           (q_in),
        .q_full           (q_full)
    );

    // job queue
    drpu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // trig and position update
    drpu_back #(
        .CORDIC_STEPS  (CORDIC_STEPS),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_out),
        .q_pop      (q_pop),
        .pose_valid (pose_valid),
        .pose_stall (pose_stall),
        .pose_x     (pose_x),
        .pose_y     (pose_y)
    );

endmodule

FILE: design/drpu_front.sv
// ----------------------------------------------------------------------------
// drpu_front
// Takes encoder samples, forms distance delta and midpoint angle, and reduces
// the angle modulo one turn in radix-4 steps before queueing the job.
// ----------------------------------------------------------------------------
module drpu_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     sample_valid,
    output logic                     sample_stall,
    input  logic signed [31:0]       right_count,
    input  logic signed [31:0]       left_count,
    input  logic signed [31:0]       heading_centideg,
    output logic                     q_push,
    output drpu_pkg::drpu_job_t      q_data,
    input  logic                     q_full
);
    import drpu_pkg::*;

    logic                  busy_reg;
    logic [4:0]            cnt_reg;
    logic [33:0]           u_reg;
    logic [ANGLE_BITS-1:0] r_reg;
    logic signed [32:0]    ds_reg;
    logic                  job_primed_reg;
    logic signed [31:0]    last_dist_reg;
    logic signed [31:0]    last_head_reg;
    logic                  primed_reg;

    logic               take;
    logic signed [32:0] sum33;
    logic signed [32:0] sum_adj;
    logic signed [31:0] dist_half;
    logic signed [32:0] ds;
    logic signed [32:0] ang;
    logic [33:0]        u;
    logic [18:0]        r4;
    logic [18:0]        r_step;

    assign sample_stall = busy_reg;
    assign take         = sample_valid && !busy_reg;
    assign q_push       = busy_reg && (cnt_reg == 5'd0) && !q_full;
    assign q_data       = '{primed: job_primed_reg, ds: ds_reg, angle: r_reg};

    // distance (truncated halving), distance delta and offset angle sum
    always_comb
    begin
        sum33     = {right_count[31], right_count} + {left_count[31], left_count};
        sum_adj   = sum33 + {32'd0, sum33[32]};
        dist_half = sum_adj[32:1];
        ds        = {dist_half[31], dist_half} - {last_dist_reg[31], last_dist_reg};
        ang       = {last_head_reg[31], last_head_reg}
                  + {heading_centideg[31], heading_centideg};
        u         = {ang[32], ang} + U_OFFSET;
    end

    // one radix-4 remainder step
    always_comb
    begin
        r4 = {r_reg, u_reg[33:32]};
        if (r4 >= TURN_X3)
        begin
            r_step = r4 - TURN_X3;
        end
        else if (r4 >= TURN_X2)
        begin
            r_step = r4 - TURN_X2;
        end
        else if (r4 >= TURN_X1)
        begin
            r_step = r4 - TURN_X1;
        end
        else
        begin
            r_step = r4;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            cnt_reg        <= '0;
            primed_reg     <= 1'b0;
            last_dist_reg  <= '0;
            last_head_reg  <= '0;
            job_primed_reg <= 1'b0;
        end
        else if (take)
        begin
            busy_reg       <= 1'b1;
            cnt_reg        <= 5'(U_STEPS);
            job_primed_reg <= primed_reg;
            primed_reg     <= 1'b1;
            last_dist_reg  <= dist_half;
            last_head_reg  <= heading_centideg;
        end
        else if (busy_reg && cnt_reg != 5'd0)
        begin
            cnt_reg <= cnt_reg - 5'd1;
        end
        else if (q_push)
        begin
            busy_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            u_reg  <= u;
            r_reg  <= '0;
            ds_reg <= ds;
        end
        else if (busy_reg && cnt_reg != 5'd0)
        begin
            u_reg <= {u_reg[31:0], 2'b00};
            r_reg <= r_step[ANGLE_BITS-1:0];
        end
    end

endmodule

FILE: design/drpu_queue.sv
// ----------------------------------------------------------------------------
// drpu_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`include "dead_reckoning_pose_update_defines.svh"

module drpu_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  drpu_pkg::drpu_job_t push_data,
    output logic                full,
    input  logic                pop,
    output drpu_pkg::drpu_job_t pop_data,
    output logic                empty
);
    import drpu_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    drpu_job_t       mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `DRPU_ASSERT_NOW(a_no_push_full, full, !push, "request pushed into a full queue")
    `DRPU_ASSERT_NOW(a_no_pop_empty, empty, !pop, "request popped from an empty queue")
    `DRPU_ASSERT_NEXT(a_pop_drains, (pop && !push), (count_reg == $past(count_reg) - 1'b1),
        "queue level did not fall on pop")

endmodule

FILE: design/drpu_back.sv
// ----------------------------------------------------------------------------
// drpu_back
// Angle to radians, CORDIC sin/cos, distance products and saturating
// position update; holds the result register.
// ----------------------------------------------------------------------------
module drpu_back #(
    parameter int CORDIC_STEPS  = drpu_pkg::CORDIC_STEPS_DEF,
    parameter int POSITION_BITS = drpu_pkg::POSITION_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  drpu_pkg::drpu_job_t q_data,
    output logic                q_pop,
    output logic                pose_valid,
    input  logic                pose_stall,
    output logic signed [31:0]  pose_x,
    output logic signed [31:0]  pose_y
);
    import drpu_pkg::*;

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int PB = POSITION_BITS;
    localparam int SW = ((PB > 35) ? PB : 35) + 1;
    localparam int OW = (PB > 32) ? PB : 32;
    localparam logic signed [SW-1:0] PMAX = {{(SW-PB+1){1'b0}}, {(PB-1){1'b1}}};
    localparam logic signed [SW-1:0] PMIN = ~PMAX;
    localparam logic signed [OW-1:0] OMAX = {{(OW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [OW-1:0] OMIN = ~OMAX;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_QUAD  = 4'd1;
    localparam logic [3:0] S_MUL1  = 4'd2;
    localparam logic [3:0] S_MUL2  = 4'd3;
    localparam logic [3:0] S_ZSUM  = 4'd4;
    localparam logic [3:0] S_ROT   = 4'd5;
    localparam logic [3:0] S_TRIG  = 4'd6;
    localparam logic [3:0] S_MULXY = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_ACC   = 4'd9;

    logic [3:0]             state_reg;
    logic [IW-1:0]          i_reg;
    drpu_job_t              job_reg;
    logic [1:0]             quad_reg;
    logic [14:0]            rem_reg;
    logic [28:0]            p1_reg;
    logic [31:0]            p2_reg;
    logic [13:0]            q_reg;
    logic signed [19:0]     x_reg;
    logic signed [19:0]     y_reg;
    logic signed [32:0]     z_reg;
    logic signed [17:0]     c_reg;
    logic signed [17:0]     s_reg;
    logic signed [50:0]     px_reg;
    logic signed [50:0]     py_reg;
    logic signed [34:0]     ix_reg;
    logic signed [34:0]     iy_reg;
    logic signed [PB-1:0]   pos_x_reg;
    logic signed [PB-1:0]   pos_y_reg;
    logic                   pose_valid_reg;
    logic signed [31:0]     pose_x_reg;
    logic signed [31:0]     pose_y_reg;

    logic                   out_free;
    logic                   commit;
    logic [1:0]             quad;
    logic [ANGLE_BITS-1:0]  rem_full;
    logic [48:0]            recip_prod;
    logic signed [19:0]     dx;
    logic signed [19:0]     dy;
    logic signed [32:0]     atan_v;
    logic signed [17:0]     xc;
    logic signed [17:0]     yc;
    logic signed [SW-1:0]   sum_x;
    logic signed [SW-1:0]   sum_y;
    logic signed [PB-1:0]   pos_x_next;
    logic signed [PB-1:0]   pos_y_next;
    logic signed [OW-1:0]   ox;
    logic signed [OW-1:0]   oy;

    assign pose_valid = pose_valid_reg;
    assign pose_x     = pose_x_reg;
    assign pose_y     = pose_y_reg;
    assign out_free   = !pose_valid_reg || !pose_stall;
    assign q_pop      = (state_reg == S_IDLE) && !q_empty;
    assign commit     = (state_reg == S_ACC) && out_free;

    // quadrant split of the reduced angle
    always_comb
    begin
        if (job_reg.angle >= TURN_3Q)
        begin
            quad     = 2'd3;
            rem_full = job_reg.angle - TURN_3Q;
        end
        else if (job_reg.angle >= TURN_2Q)
        begin
            quad     = 2'd2;
            rem_full = job_reg.angle - TURN_2Q;
        end
        else if (job_reg.angle >= TURN_1Q)
        begin
            quad     = 2'd1;
            rem_full = job_reg.angle - TURN_1Q;
        end
        else
        begin
            quad     = 2'd0;
            rem_full = job_reg.angle;
        end
    end

    // exact divide by 1125 after the shift by 5
    assign recip_prod = p1_reg[28:5] * RECIP_1125;

    // one CORDIC rotation, floor shifts
    always_comb
    begin
        dx     = y_reg >>> i_reg;
        dy     = x_reg >>> i_reg;
        atan_v = {2'b00, atan_q30(5'(i_reg))};
    end

    // clamp to plus or minus one
    always_comb
    begin
        xc = (x_reg > ONE_POS) ? 18'(ONE_POS) : ((x_reg < ONE_NEG) ? 18'(ONE_NEG) : 18'(x_reg));
        yc = (y_reg > ONE_POS) ? 18'(ONE_POS) : ((y_reg < ONE_NEG) ? 18'(ONE_NEG) : 18'(y_reg));
    end

    // saturating position add, widened for the output clamp
    always_comb
    begin
        sum_x = SW'(pos_x_reg) + SW'(ix_reg);
        sum_y = SW'(pos_y_reg) + SW'(iy_reg);
        pos_x_next = (sum_x > PMAX) ? PB'(PMAX) : ((sum_x < PMIN) ? PB'(PMIN) : PB'(sum_x));
        pos_y_next = (sum_y > PMAX) ? PB'(PMAX) : ((sum_y < PMIN) ? PB'(PMIN) : PB'(sum_y));
        ox = OW'(pos_x_next);
        oy = OW'(pos_y_next);
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= q_data.primed ? S_QUAD : S_ACC;
                    end
                end
                S_QUAD:  state_reg <= S_MUL1;
                S_MUL1:  state_reg <= S_MUL2;
                S_MUL2:  state_reg <= S_ZSUM;
                S_ZSUM:
                begin
                    state_reg <= S_ROT;
                    i_reg     <= '0;
                end
                S_ROT:
                begin
                    if (i_reg == IW'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= S_TRIG;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_TRIG:  state_reg <= S_MULXY;
                S_MULXY: state_reg <= S_DIV;
                S_DIV:   state_reg <= S_ACC;
                S_ACC:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    job_reg <= q_data;
                    ix_reg  <= '0;
                    iy_reg  <= '0;
                end
            end
            S_QUAD:
            begin
                quad_reg <= quad;
                rem_reg  <= rem_full[14:0];
            end
            S_MUL1:
            begin
                p1_reg <= 29'(rem_reg) * PI_REM + ROUND_HALF;
                p2_reg <= 32'(rem_reg) * PI_QUOT;
            end
            S_MUL2:  q_reg <= recip_prod[48:35];
            S_ZSUM:
            begin
                x_reg <= CORDIC_GAIN;
                y_reg <= '0;
                z_reg <= signed'({1'b0, p2_reg + {18'd0, q_reg}});
            end
            S_ROT:
            begin
                if (!z_reg[32])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_v;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_v;
                end
            end
            S_TRIG:
            begin
                case (quad_reg)
                    2'd0:
                    begin
                        c_reg <= xc;
                        s_reg <= yc;
                    end
                    2'd1:
                    begin
                        c_reg <= -yc;
                        s_reg <= xc;
                    end
                    2'd2:
                    begin
                        c_reg <= -xc;
                        s_reg <= -yc;
                    end
                    default:
                    begin
                        c_reg <= yc;
                        s_reg <= -xc;
                    end
                endcase
            end
            S_MULXY:
            begin
                px_reg <= 51'(job_reg.ds) * 51'(c_reg);
                py_reg <= 51'(job_reg.ds) * 51'(s_reg);
            end
            S_DIV:
            begin
                ix_reg <= 35'((px_reg + (px_reg[50] ? 51'sd65535 : 51'sd0)) >>> 16);
                iy_reg <= 35'((py_reg + (py_reg[50] ? 51'sd65535 : 51'sd0)) >>> 16);
            end
            default:
            begin
            end
        endcase
    end

    // kept position and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            pose_valid_reg <= 1'b0;
            pose_x_reg     <= '0;
            pose_y_reg     <= '0;
        end
        else if (commit)
        begin
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            pose_valid_reg <= 1'b1;
            pose_x_reg     <= (ox > OMAX) ? 32'sh7FFFFFFF : ((ox < OMIN) ? 32'sh80000000 : ox[31:0]);
            pose_y_reg     <= (oy > OMAX) ? 32'sh7FFFFFFF : ((oy < OMIN) ? 32'sh80000000 : oy[31:0]);
        end
        else if (!pose_stall)
        begin
            pose_valid_reg <= 1'b0;
        end
    end

endmodule

FILE: dv/tb_dead_reckoning_pose_update.sv
// ----------------------------------------------------------------------------
// tb_dead_reckoning_pose_update
// Self-checking bench for the odometry pose tracker: a bit-exact pose
// predictor (distance average, midpoint CORDIC, truncated increments,
// saturating position) fed from accepted samples, checked against each pose.
// ----------------------------------------------------------------------------
class pose_scoreboard;
    longint prev_dist;
    longint prev_head;
    longint pos_x;
    longint pos_y;
    bit     seen;
    logic signed [31:0] exp_x_q[$];
    logic signed [31:0] exp_y_q[$];
    int     mismatches;
    int     checked;

    function new();
        prev_dist = 0;
        prev_head = 0;
        pos_x = 0;
        pos_y = 0;
        seen = 0;
        mismatches = 0;
        checked = 0;
    endfunction

    static function longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    static function longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Midpoint angle in half-centidegrees to cos/sin in Q1.16
    static function void midpoint_trig(longint ang2, output longint c, output longint s);
        longint r;
        longint rem;
        longint z;
        longint vx;
        longint vy;
        longint dx;
        longint dy;
        longint atan_tab[24];
        int quad;
        atan_tab = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                     64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                     64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                     64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                     64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                     64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
        r = ang2 % 72000;
        if (r < 0)
            r += 72000;
        quad = int'(r / 18000);
        rem = r % 18000;
        z = (rem * 64'd3373259426 + 18000) / 36000;
        vx = 39797;
        vy = 0;
        for (int i = 0; i < 16; i++)
        begin
            dx = floor_shr(vy, i);
            dy = floor_shr(vx, i);
            if (z >= 0)
            begin
                vx -= dx; vy += dy; z -= atan_tab[i];
            end
            else
            begin
                vx += dx; vy -= dy; z += atan_tab[i];
            end
        end
        vx = clip(vx, -65536, 65536);
        vy = clip(vy, -65536, 65536);
        case (quad)
            0: begin c = vx;  s = vy;  end
            1: begin c = -vy; s = vx;  end
            2: begin c = -vx; s = -vy; end
            default: begin c = vy; s = -vx; end
        endcase
    endfunction

    // Accepted sample: advance the predicted pose and queue it
    function void note_sample(logic signed [31:0] rc, logic signed [31:0] lc,
                              logic signed [31:0] hd);
        longint avg_dist;
        longint ds;
        longint c;
        longint s;
        longint lim;
        lim = 64'sd2147483647;
        avg_dist = (longint'(rc) + longint'(lc)) / 2;
        if (seen)
        begin
            ds = avg_dist - prev_dist;
            midpoint_trig(prev_head + longint'(hd), c, s);
            pos_x = clip(pos_x + (ds * c) / 65536, -lim - 1, lim);
            pos_y = clip(pos_y + (ds * s) / 65536, -lim - 1, lim);
        end
        prev_dist = avg_dist;
        prev_head = longint'(hd);
        seen = 1;
        exp_x_q.push_back(pos_x[31:0]);
        exp_y_q.push_back(pos_y[31:0]);
    endfunction

    function void check_pose(logic signed [31:0] px, logic signed [31:0] py);
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        if (exp_x_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected pose x=%0d y=%0d", px, py);
            return;
        end
        ex = exp_x_q.pop_front();
        ey = exp_y_q.pop_front();
        checked++;
        if (px !== ex || py !== ey)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("pose %0d mismatch: exp x=%0d y=%0d got x=%0d y=%0d",
                         checked, ex, ey, px, py);
        end
    endfunction
endclass

module tb_dead_reckoning_pose_update;
    logic               clk;
    logic               rst_n;
    logic               sample_valid;
    logic               sample_stall;
    logic signed [31:0] right_count;
    logic signed [31:0] left_count;
    logic signed [31:0] heading_centideg;
    logic               pose_valid;
    logic               pose_stall;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;

    pose_scoreboard sb;
    bit  quiet_phase;
    bit  hold_off_done;
    bit  sending_done;
    int  idle_cycles;
    int  samples_sent;

    dead_reckoning_pose_update dut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall),
        .right_count(right_count), .left_count(left_count),
        .heading_centideg(heading_centideg),
        .pose_valid(pose_valid), .pose_stall(pose_stall),
        .pose_x(pose_x), .pose_y(pose_y)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Present one request and hold it until accepted
    task automatic send_sample(logic signed [31:0] rc, logic signed [31:0] lc,
                               logic signed [31:0] hd);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        right_count <= rc;
        left_count <= lc;
        heading_centideg <= hd;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        sb.note_sample(rc, lc, hd);
        samples_sent++;
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'sh7FFFFFFF - $urandom_range(0, 3);
            2: return 32'sh80000000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 20000)) - 10000;
        endcase
    endfunction

    // Stimulus
    initial
    begin
        logic signed [31:0] r;
        logic signed [31:0] l;
        logic signed [31:0] h;
        sb = new();
        rst_n = 0;
        sample_valid = 0;
        right_count = 0;
        left_count = 0;
        heading_centideg = 0;
        quiet_phase = 0;
        sending_done = 0;
        samples_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: priming, each quadrant, extremes, saturation, wrap
        send_sample(0, 0, 0);
        send_sample(1000, 1000, 0);
        send_sample(2000, 2000, 18000);
        send_sample(3000, 3000, 18000);
        send_sample(4000, 4000, 36000);
        send_sample(5000, 5000, -9000);
        send_sample(-5000, -5000, 4500);
        send_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_sample(32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
        send_sample(32'sh80000000, 32'sh80000000, 0);
        send_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
        send_sample(32'sh80000000, 32'sh80000000, 0);
        send_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
        send_sample(32'sh7FFFFFFF, 32'sh80000000, 36000);
        send_sample(32'sh80000000, 32'sh80000000, 36000);
        send_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 36000);
        send_sample(-1, 0, -1);
        send_sample(-3, 0, 72000);
        send_sample(32'sh80000000, 32'sh7FFFFFFF, 54000);
        // random: mostly smooth motion, sometimes wild jumps
        r = 0; l = 0; h = 0;
        for (int i = 0; i < 1650; i++)
        begin
            if (i == 1400)
                quiet_phase = 1;
            if ($urandom_range(0, 4) == 0)
            begin
                r = rand_word(); l = rand_word(); h = rand_word();
            end
            else
            begin
                r = r + $signed($urandom_range(0, 4000)) - 2000;
                l = l + $signed($urandom_range(0, 4000)) - 2000;
                h = h + $signed($urandom_range(0, 2000)) - 1000;
            end
            send_sample(r, l, h);
        end
        sample_valid <= 1'b0;
        sending_done = 1;
    end

    // Receiver: random stall bursts, one long hold-off early on
    initial
    begin
        int n;
        pose_stall = 1;
        hold_off_done = 0;
        @(posedge rst_n);
        pose_stall <= 0;
        forever
        begin
            @(posedge clk);
            if (!hold_off_done && samples_sent >= 30)
            begin
                hold_off_done = 1;
                pose_stall <= 1'b1;
                repeat (400) @(posedge clk);
                pose_stall <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 8);
                pose_stall <= 1'b1;
                repeat (n) @(posedge clk);
                pose_stall <= 1'b0;
            end
        end
    end

    // Result check at each edge
    always @(posedge clk)
    begin
        if (rst_n && pose_valid && !pose_stall)
            sb.check_pose(pose_x, pose_y);
    end

    // Watchdog and end of run
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((sample_valid && !sample_stall) || (pose_valid && !pose_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > 5000)
            begin
                $display("watchdog: no progress, %0d poses still expected",
                         sb.exp_x_q.size());
                $display("[dead_reckoning_pose_update] ERROR");
                $finish;
            end
            if (sending_done && sb.exp_x_q.size() == 0)
                break;
        end
        repeat (100) @(posedge clk);
        $display("covered %0d samples, %0d poses checked, %0d mismatches",
                 samples_sent, sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.exp_x_q.size() == 0)
            $display("[dead_reckoning_pose_update] OK");
        else
            $display("[dead_reckoning_pose_update] ERROR");
        $finish;
    end
endmodule
